>>> sv/rbde_pkg.sv
// Shared types, constants and the month length table for the RTC BCD date to
// epoch seconds converter. No dependencies.
package rbde_pkg;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int SECS_W   = 34;
   localparam int OPND_W   = 17;
   localparam int MONTH_W  = 4;
   localparam int LEAPS_W  = 6;

   // Calendar constants
   localparam logic [7:0]        HOUR24_MASK    = 8'h3f;
   localparam logic [7:0]        YEARS_TO_2000  = 8'd30;
   localparam logic [11:0]       BASE_MINUS_ONE = 12'd1999;
   localparam logic [11:0]       LEAPS_TO_1970  = 12'd492;
   localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
   localparam logic [OPND_W-1:0] DAYS_PER_YEAR  = 17'd365;
   localparam logic [OPND_W-1:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [OPND_W-1:0] SECS_PER_HOUR  = 17'd3600;
   localparam logic [OPND_W-1:0] SECS_PER_MIN   = 17'd60;
   localparam logic [OPND_W-1:0] UNIT           = 17'd1;

   // Input word
   typedef struct packed {
      logic [BYTE_W-1:0] year_bcd;
      logic [BYTE_W-1:0] month_bcd;
      logic [BYTE_W-1:0] day_bcd;
      logic [BYTE_W-1:0] hour_bcd;
      logic [BYTE_W-1:0] minute_bcd;
      logic [BYTE_W-1:0] second_bcd;
      logic              hour24_mode;
   } req_type;

   // Result word
   typedef struct packed {
      logic [SECS_W-1:0] epoch_seconds;
      logic              bad_field;
   } rsp_type;

   // Decoded date, held for the whole conversion
   typedef struct packed {
      logic [BYTE_W-1:0]  years;     // whole years since 1970
      logic [LEAPS_W-1:0] leaps;     // leap days before this year
      logic               leap;      // this year is a leap year
      logic [MONTH_W-1:0] month;
      logic [BYTE_W-1:0]  day_m1;    // days before the current day
      logic [BYTE_W-1:0]  hour;
      logic [BYTE_W-1:0]  minute;
      logic [BYTE_W-1:0]  second;
      logic               bad;
   } dec_type;

   // Control of the shared multiply-accumulate unit
   typedef struct packed {
      logic              en;
      logic              clr;
      logic [OPND_W-1:0] a;
      logic [OPND_W-1:0] b;
   } mac_ctrl_type;

   // Sequencer states, one-hot
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_YEAR  = 10'b00_0000_0010,
      ST_LEAP  = 10'b00_0000_0100,
      ST_MONTH = 10'b00_0000_1000,
      ST_DAY   = 10'b00_0001_0000,
      ST_SCALE = 10'b00_0010_0000,
      ST_HOUR  = 10'b00_0100_0000,
      ST_MIN   = 10'b00_1000_0000,
      ST_SEC   = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   // Packed BCD byte to binary, nibbles 10..15 taken as they are
   function automatic logic [BYTE_W-1:0] bcd_decode(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] hi;
      hi = {4'd0, b[7:4]};
      return {4'd0, b[3:0]} + (hi << 3) + (hi << 1);
   endfunction

   // Days in a month of a common year, month 1..12
   function automatic logic [OPND_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [OPND_W-1:0] len;
      unique case (m)
         4'd2:                      len = 17'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 17'd30;
         default:                   len = 17'd31;
      endcase
      return len;
   endfunction

endpackage

>>> sv/rbde_decode.sv
// Input word decoder: BCD to binary, hour masking, field checks and the
// per-year figures. Depends on rbde_pkg.
module rbde_decode (
   input  rbde_pkg::req_type req,
   output rbde_pkg::dec_type dec
);

   logic [7:0]  year_d;
   logic [7:0]  month_d;
   logic [7:0]  day_d;
   logic [7:0]  hour_raw;
   logic [11:0] leap_sum;
   logic [11:0] leap_cnt;

   // Decode every byte
   always_comb begin
      hour_raw = req.hour24_mode ? (req.hour_bcd & rbde_pkg::HOUR24_MASK) : req.hour_bcd;
      year_d   = rbde_pkg::bcd_decode(req.year_bcd);
      month_d  = rbde_pkg::bcd_decode(req.month_bcd);
      day_d    = rbde_pkg::bcd_decode(req.day_bcd);
      leap_sum = rbde_pkg::BASE_MINUS_ONE + {4'd0, year_d};
      leap_cnt = (leap_sum >> 2) - rbde_pkg::LEAPS_TO_1970;

      dec.years  = rbde_pkg::YEARS_TO_2000 + year_d;
      dec.leaps  = leap_cnt[rbde_pkg::LEAPS_W-1:0];
      dec.leap   = (year_d[1:0] == 2'b00);   // 2000 is a multiple of four
      dec.month  = month_d[rbde_pkg::MONTH_W-1:0];
      dec.day_m1 = day_d - 8'd1;
      dec.hour   = rbde_pkg::bcd_decode(hour_raw);
      dec.minute = rbde_pkg::bcd_decode(req.minute_bcd);
      dec.second = rbde_pkg::bcd_decode(req.second_bcd);
      dec.bad    = (month_d < {4'd0, rbde_pkg::MONTH_JAN}) ||
                   (month_d > {4'd0, rbde_pkg::MONTH_DEC}) ||
                   (day_d == 8'd0);
   end

endmodule

>>> sv/rbde_mac.sv
// Shared multiply-accumulate unit: when en is set, acc <= (clr ? 0 : acc) + a * b.
// Depends on rbde_pkg.
module rbde_mac (
   input  logic                              clock,
   input  rbde_pkg::mac_ctrl_type            ctrl,
   output logic [rbde_pkg::SECS_W-1:0]       acc
);

   logic [rbde_pkg::SECS_W-1:0] acc_ff;
   logic [rbde_pkg::SECS_W-1:0] acc_in;
   logic [rbde_pkg::SECS_W-1:0] prod;

   // 17 x 17 product into the 34-bit accumulator
   always_comb begin
      prod   = ctrl.a * ctrl.b;
      acc_in = (ctrl.clr ? '0 : acc_ff) + prod;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

>>> sv/rtc_bcd_date_to_epoch_seconds_core.sv
// Top level of the RTC BCD date to epoch seconds converter: sequencer and
// output register. Depends on rbde_pkg, rbde_decode and rbde_mac.
//
// Takes one raw RTC date word (packed BCD) and returns the seconds since
// 1970-01-01 00:00:00, with no century rule for leap years. A single
// multiply-accumulate unit is stepped through years, leap days, the whole
// months before the current one, one per cycle, days, the scaling to
// seconds, hours, minutes and seconds. A date with a bad month or zero day
// skips these steps and gives zero with bad_field set. The input is not
// ready while a conversion runs; the result register lets the next word be
// taken while a result waits.
module rtc_bcd_date_to_epoch_seconds_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rbde_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rbde_pkg::rsp_type rsp_payload
);

   rbde_pkg::state_type              state_ff, state_in;
   rbde_pkg::dec_type                dec_ff, dec_now;
   rbde_pkg::mac_ctrl_type           mac_ctrl;
   logic [rbde_pkg::MONTH_W-1:0]     mon_ff, mon_in;
   logic [rbde_pkg::SECS_W-1:0]      acc;
   logic                             rsp_valid_ff, rsp_valid_in;
   rbde_pkg::rsp_type                rsp_ff;
   logic                             req_fire;
   logic                             rsp_load;

   rbde_decode u_decode (
      .req (req_payload),
      .dec (dec_now)
   );

   rbde_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .acc   (acc)
   );

   assign req_ready = (state_ff == rbde_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == rbde_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer and MAC operand selection
   always_comb begin
      state_in      = state_ff;
      mon_in        = mon_ff;
      mac_ctrl.en   = 1'b0;
      mac_ctrl.clr  = 1'b0;
      mac_ctrl.a    = '0;
      mac_ctrl.b    = rbde_pkg::UNIT;
      unique case (state_ff)
         rbde_pkg::ST_IDLE: begin
            mon_in = rbde_pkg::MONTH_JAN;
            if (req_fire) begin
               state_in = dec_now.bad ? rbde_pkg::ST_DONE : rbde_pkg::ST_YEAR;
            end
         end
         rbde_pkg::ST_YEAR: begin
            mac_ctrl.en  = 1'b1;
            mac_ctrl.clr = 1'b1;
            mac_ctrl.a   = {9'd0, dec_ff.years};
            mac_ctrl.b   = rbde_pkg::DAYS_PER_YEAR;
            state_in     = rbde_pkg::ST_LEAP;
         end
         rbde_pkg::ST_LEAP: begin
            mac_ctrl.en = 1'b1;
            mac_ctrl.a  = {11'd0, dec_ff.leaps};
            state_in    = rbde_pkg::ST_MONTH;
         end
         rbde_pkg::ST_MONTH: begin
            // one whole month per cycle, February gains a day in leap years
            if (mon_ff < dec_ff.month) begin
               mac_ctrl.en = 1'b1;
               mac_ctrl.a  = rbde_pkg::month_len(mon_ff) +
                  {16'd0, (mon_ff == rbde_pkg::MONTH_FEB) && dec_ff.leap};
               mon_in      = mon_ff + 4'd1;
            end else begin
               state_in = rbde_pkg::ST_DAY;
            end
         end
         rbde_pkg::ST_DAY: begin
            mac_ctrl.en = 1'b1;
            mac_ctrl.a  = {9'd0, dec_ff.day_m1};
            state_in    = rbde_pkg::ST_SCALE;
         end
         rbde_pkg::ST_SCALE: begin
            // day count fits 17 bits here
            mac_ctrl.en  = 1'b1;
            mac_ctrl.clr = 1'b1;
            mac_ctrl.a   = acc[rbde_pkg::OPND_W-1:0];
            mac_ctrl.b   = rbde_pkg::SECS_PER_DAY;
            state_in     = rbde_pkg::ST_HOUR;
         end
         rbde_pkg::ST_HOUR: begin
            mac_ctrl.en = 1'b1;
            mac_ctrl.a  = {9'd0, dec_ff.hour};
            mac_ctrl.b  = rbde_pkg::SECS_PER_HOUR;
            state_in    = rbde_pkg::ST_MIN;
         end
         rbde_pkg::ST_MIN: begin
            mac_ctrl.en = 1'b1;
            mac_ctrl.a  = {9'd0, dec_ff.minute};
            mac_ctrl.b  = rbde_pkg::SECS_PER_MIN;
            state_in    = rbde_pkg::ST_SEC;
         end
         rbde_pkg::ST_SEC: begin
            mac_ctrl.en = 1'b1;
            mac_ctrl.a  = {9'd0, dec_ff.second};
            state_in    = rbde_pkg::ST_DONE;
         end
         rbde_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = rbde_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbde_pkg::ST_IDLE;
         end
      endcase
   end

   // Output handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbde_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mon_ff <= mon_in;
      if (req_fire) begin
         dec_ff <= dec_now;
      end
      if (rsp_load) begin
         rsp_ff.epoch_seconds <= dec_ff.bad ? '0 : acc;
         rsp_ff.bad_field     <= dec_ff.bad;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> sv/rbde_checker.sv
// Port-level checks for the RTC BCD date to epoch seconds converter, bound
// to the top level. Depends on rbde_pkg.
module rbde_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rbde_pkg::rsp_type rsp_payload
);

   // A waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   // A flagged date reads as zero seconds
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bad_field |-> rsp_payload.epoch_seconds == '0)
      else $error("flagged result carries nonzero seconds");

   // Busy once a word is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready straight after acceptance");

   // No result appears in the cycle after acceptance
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind rtc_bcd_date_to_epoch_seconds_core rbde_checker u_rbde_checker (.*);

>>> test/rbde_epoch_checker.sv
`timescale 1ns / 100ps
// Checker for the RTC BCD date to epoch seconds converter: watches both
// channels, predicts each result and compares it. Depends on rbde_pkg.
module rbde_epoch_checker
   import rbde_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pend_count
);

   localparam int unsigned EPOCH_YEAR   = 1970;
   localparam int unsigned CENTURY_YEAR = 2000;
   localparam longint unsigned DAY_SECS  = 86400;
   localparam longint unsigned HOUR_SECS = 3600;
   localparam longint unsigned MIN_SECS  = 60;

   rsp_type epoch_due_q[$];
   rsp_type due;

   // Packed BCD byte as low nibble plus ten times the high one, no digit check
   function automatic int unsigned bcd_value(input logic [7:0] b);
      return int'(b[3:0]) + 10 * int'(b[7:4]);
   endfunction

   // Seconds since 1970 for one raw RTC date word
   function automatic rsp_type date_to_seconds(input req_type w);
      rsp_type r;
      logic [7:0] hour_raw;
      int unsigned yr, mon, dd, hh, mm, ss, days;
      longint unsigned secs;
      hour_raw = w.hour24_mode ? (w.hour_bcd & HOUR24_MASK) : w.hour_bcd;
      yr  = CENTURY_YEAR + bcd_value(w.year_bcd);
      mon = bcd_value(w.month_bcd);
      dd  = bcd_value(w.day_bcd);
      hh  = bcd_value(hour_raw);
      mm  = bcd_value(w.minute_bcd);
      ss  = bcd_value(w.second_bcd);
      r = '0;
      if (mon < 1 || mon > 12 || dd == 0) begin
         r.bad_field = 1'b1;
         return r;
      end
      // whole years, leap every fourth year with no century rule
      days = 365 * (yr - EPOCH_YEAR) + (yr - 1) / 4 - (EPOCH_YEAR - 1) / 4;
      for (int m = 1; m < mon; m++) begin
         case (m)
            2:           days += (yr % 4 == 0) ? 29 : 28;
            4, 6, 9, 11: days += 30;
            default:     days += 31;
         endcase
      end
      days += dd - 1;
      secs = longint'(days) * DAY_SECS + longint'(hh) * HOUR_SECS
           + longint'(mm) * MIN_SECS + longint'(ss);
      r.epoch_seconds = secs[SECS_W-1:0];
      return r;
   endfunction

   // Results are checked before the new word is queued: a word never
   // comes back in the cycle it goes in
   always @(posedge clock) begin
      if (reset) begin
         epoch_due_q.delete();
         pend_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (epoch_due_q.size() == 0) begin
               fail_count++;
               $display("%0t: result with none due: secs=%0d bad=%0b",
                        $time, rsp_payload.epoch_seconds, rsp_payload.bad_field);
            end else begin
               due = epoch_due_q.pop_front();
               if (rsp_payload.epoch_seconds !== due.epoch_seconds) begin
                  fail_count++;
                  $display("%0t: epoch_seconds expected %0d, got %0d",
                           $time, due.epoch_seconds, rsp_payload.epoch_seconds);
               end
               if (rsp_payload.bad_field !== due.bad_field) begin
                  fail_count++;
                  $display("%0t: bad_field expected %0b, got %0b",
                           $time, due.bad_field, rsp_payload.bad_field);
               end
            end
         end
         if (req_valid && req_ready)
            epoch_due_q.push_back(date_to_seconds(req_payload));
         pend_count = epoch_due_q.size();
      end
   end

endmodule

>>> test/tb_rtc_bcd_date_to_epoch_seconds_core.sv
`timescale 1ns / 100ps
// Testbench top for rtc_bcd_date_to_epoch_seconds_core: drives date words
// and result stalls, gives the verdict. Depends on rbde_pkg, rbde_epoch_checker.
module tb_rtc_bcd_date_to_epoch_seconds_core;
   import rbde_pkg::*;

   localparam int RAND_WORDS = 1200;
   localparam int RX_OPEN    = 0;
   localparam int RX_THIRDS  = 1;
   localparam int RX_COIN    = 2;
   localparam int RX_SPARSE  = 3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   int      fail_count;
   int      pend_count;
   int      burst_left;

   rtc_bcd_date_to_epoch_seconds_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   rbde_epoch_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pend_count  (pend_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Guard against a hung handshake
   initial begin
      #1000000;
      $display("tb_rtc_bcd_date_to_epoch_seconds_core NOT OK");
      $finish;
   end

   // Receiver: stall pattern switches between several shapes
   initial begin
      int mode, span, tick;
      rsp_ready = 1'b0;
      span = 0;
      tick = 0;
      mode = RX_OPEN;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            mode = $urandom_range(RX_OPEN, RX_SPARSE);
            span = $urandom_range(16, 64);
         end
         span--;
         tick++;
         case (mode)
            RX_OPEN:   rsp_ready = 1'b1;
            RX_THIRDS: rsp_ready = (tick % 3) != 0;
            RX_COIN:   rsp_ready = 1'($urandom_range(0, 1));
            default:   rsp_ready = (tick % 4) == 0;
         endcase
      end
   end

   function automatic logic [7:0] to_bcd(input int v);
      return 8'(((v / 10) << 4) | (v % 10));
   endfunction

   // Offer one word, hold it until taken, then idle in bursts
   task automatic send_word(input req_type w);
      int gap;
      req_payload = w;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic send_date(input logic [7:0] y, mo, d, h, mi, s, input logic h24);
      req_type w;
      w.year_bcd    = y;
      w.month_bcd   = mo;
      w.day_bcd     = d;
      w.hour_bcd    = h;
      w.minute_bcd  = mi;
      w.second_bcd  = s;
      w.hour24_mode = h24;
      send_word(w);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pend_count != 0) @(negedge clock);
   endtask

   initial begin
      req_type w;
      int kind;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      burst_left  = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, flags, masking, leap handling
      send_date(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);  // all zero, flagged
      send_date(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1);  // first second of 2000
      send_date(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59, 1'b1);  // last second of 2099
      send_date(8'hff, 8'h12, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0);  // largest good date
      send_date(8'hff, 8'h0c, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);  // hex month twelve
      send_date(8'h24, 8'h13, 8'h10, 8'h10, 8'h10, 8'h10, 1'b1);  // month thirteen
      send_date(8'h24, 8'hff, 8'h10, 8'h10, 8'h10, 8'h10, 1'b0);  // month far out
      send_date(8'h24, 8'h05, 8'h00, 8'h10, 8'h10, 8'h10, 1'b1);  // day zero
      send_date(8'h24, 8'h0a, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1);  // hex month ten
      send_date(8'h24, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1);  // BCD month ten
      send_date(8'h31, 8'h06, 8'h15, 8'hd2, 8'h30, 8'h30, 1'b1);  // upper hour bits masked
      send_date(8'h31, 8'h06, 8'h15, 8'hd2, 8'h30, 8'h30, 1'b0);  // same hour unmasked
      send_date(8'h24, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00, 1'b1);  // leap day
      send_date(8'h24, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1);  // after leap Feb
      send_date(8'h23, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1);  // after common Feb
      send_date(8'h23, 8'h02, 8'h31, 8'h00, 8'h00, 8'h00, 1'b1);  // day past month end
      send_date(8'haf, 8'h07, 8'hfa, 8'h3f, 8'hcc, 8'hee, 1'b1);  // hex digits in every field but the month
      send_date(8'h00, 8'h11, 8'h30, 8'h11, 8'h5a, 8'h0f, 1'b0);
      send_date(8'h50, 8'h01, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1);  // zero day, full rest

      // Random: mostly plausible dates, some raw bytes and broken dates
      for (int n = 0; n < RAND_WORDS; n++) begin
         if (n == RAND_WORDS / 2)
            wait_drained();
         kind = $urandom_range(0, 99);
         w.year_bcd = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                 : to_bcd($urandom_range(0, 99));
         w.hour24_mode = 1'($urandom_range(0, 1));
         if (kind < 75) begin
            w.month_bcd  = to_bcd($urandom_range(1, 12));
            w.day_bcd    = to_bcd($urandom_range(1, 31));
            w.hour_bcd   = to_bcd($urandom_range(0, 23));
            if (w.hour24_mode)
               w.hour_bcd[7:6] = 2'($urandom);
            w.minute_bcd = to_bcd($urandom_range(0, 59));
            w.second_bcd = to_bcd($urandom_range(0, 59));
         end else begin
            w.month_bcd  = 8'($urandom);
            w.day_bcd    = 8'($urandom);
            w.hour_bcd   = 8'($urandom);
            w.minute_bcd = 8'($urandom);
            w.second_bcd = 8'($urandom);
            if (kind >= 90) begin
               if ($urandom_range(0, 1))
                  w.day_bcd = 8'h00;
               else
                  w.month_bcd = to_bcd($urandom_range(13, 99));
            end
         end
         send_word(w);
      end

      wait_drained();
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("tb_rtc_bcd_date_to_epoch_seconds_core OK");
      else
         $display("tb_rtc_bcd_date_to_epoch_seconds_core NOT OK");
      $finish;
   end

endmodule
